// ===== hdl/srel_pkg.sv =====
// Package for the sparse row element locator.
// Holds sizes, request and result types, configuration indexes and engine states.
// No dependencies.
package srel_pkg;

    localparam int MAX_ROWS        = 256;
    localparam int MAX_STORED_COLS = 16;
    localparam int MAX_FULL_COLS   = 4096;
    localparam int TABLE_DEPTH     = MAX_ROWS * (1 + MAX_STORED_COLS);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int WORD_W  = 13;
    localparam int SLOT_W  = $clog2(MAX_STORED_COLS + 1);
    localparam int ROW_W   = 8;
    localparam int COL_W   = 12;
    localparam int BASE_W  = 32;
    localparam int FULL_W  = 13;
    localparam int INDEX_W = 33;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_OFFSET    = 2'd0,
        CFG_STORED_COLUMNS = 2'd1,
        CFG_FULL_COLUMNS   = 2'd2
    } t_srel_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_DONE
    } t_srel_state;

    typedef struct packed {
        logic              cmd;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] table_addr;
        logic [WORD_W-1:0] table_word;
    } t_srel_req;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } t_srel_res;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [SLOT_W-1:0] stored;
        logic [FULL_W-1:0] full;
    } t_srel_cfg;

endpackage

// ===== hdl/srel_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module srel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/srel_engine.sv =====
// Lookup engine: row-slot table, scan sequencer and result register.
// Depends on srel_pkg and srel_ram.
module srel_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srel_pkg::t_srel_cfg i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  srel_pkg::t_srel_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output srel_pkg::t_srel_res o_out_res
);
    import srel_pkg::*;

    t_srel_state        r_state, n_state;
    logic               r_out_valid, n_out_valid;
    t_srel_res          r_out, n_out;
    logic [INDEX_W-1:0] r_row_base, n_row_base;
    logic [COL_W-1:0]   r_col, n_col;
    logic [COL_W-1:0]   r_off, n_off;
    logic               r_found, n_found;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [SLOT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0]  r_rd_addr, n_rd_addr;

    logic              w_accept;
    logic              w_dense;
    logic              w_out_free;
    logic [SLOT_W:0]   w_stride;
    logic [ADDR_W-1:0] w_head;
    logic [SLOT_W-1:0] w_cnt;
    logic              w_match;
    logic              w_last;
    logic              w_we;
    logic [WORD_W-1:0] w_rdata;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_dense    = (i_cfg.full == FULL_W'(i_cfg.stored));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_stride   = {1'b0, i_cfg.stored} + 1'b1;
    assign w_head     = ADDR_W'(i_in_req.row) * ADDR_W'(w_stride);
    assign w_cnt      = (w_rdata > WORD_W'(i_cfg.stored)) ? i_cfg.stored
                                                         : w_rdata[SLOT_W-1:0];
    assign w_match    = (w_rdata == WORD_W'(r_col));
    assign w_last     = (SLOT_W'(r_slot + 1'b1) == r_cnt);

    srel_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (n_rd_addr),
        .i_wdata (i_in_req.table_word),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_req.cmd == CMD_LOOKUP) begin
                    n_state = w_dense ? ST_DONE : ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_state = (w_cnt == '0) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (w_match || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        w_we        = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_row_base  = r_row_base;
        n_col       = r_col;
        n_off       = r_off;
        n_found     = r_found;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_req.cmd == CMD_WRITE) begin
                        n_rd_addr = i_in_req.table_addr;
                        w_we      = (i_in_req.table_addr < ADDR_W'(TABLE_DEPTH));
                    end else begin
                        n_rd_addr  = w_head;
                        n_row_base = INDEX_W'(i_cfg.base)
                                   + INDEX_W'(ADDR_W'(i_in_req.row) * ADDR_W'(i_cfg.stored));
                        n_col      = i_in_req.col;
                        n_off      = i_in_req.col;
                        n_found    = w_dense;
                        n_slot     = '0;
                    end
                end
            end
            ST_COUNT: begin
                n_cnt     = w_cnt;
                n_slot    = '0;
                n_rd_addr = r_rd_addr + 1'b1;
            end
            ST_SCAN: begin
                if (w_match) begin
                    n_found = 1'b1;
                    n_off   = COL_W'(r_slot);
                end else if (!w_last) begin
                    n_slot    = r_slot + 1'b1;
                    n_rd_addr = r_rd_addr + 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.found = r_found;
                    n_out.index = r_found ? (r_row_base + INDEX_W'(r_off)) : '0;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out      <= n_out;
        r_rd_addr  <= n_rd_addr;
        r_row_base <= n_row_base;
        r_col      <= n_col;
        r_off      <= n_off;
        r_found    <= n_found;
        r_slot     <= n_slot;
        r_cnt      <= n_cnt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// ===== hdl/sparse_row_element_locator_top.sv =====
// Top level of the sparse row element locator: configuration registers and engine.
// Depends on srel_pkg and srel_engine.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   i_in_req  (t_srel_req)
//   out       output     o_out_valid / i_out_ready o_out_res (t_srel_res)
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A table write is done in the idle state. A dense lookup goes straight to the done
// state; a sparse lookup reads the row's count word, then scans one slot per table
// read, one read per cycle on the single RAM port, to a match or the last slot.
// A finished result waits in the output register while the next request is taken.
// Reset clears control state only; the table holds nothing until written.
module sparse_row_element_locator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srel_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srel_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  srel_pkg::t_srel_req              i_in_req,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output srel_pkg::t_srel_res              o_out_res
);
    import srel_pkg::*;

    logic [BASE_W-1:0] r_base;
    logic [4:0]        r_stored;
    logic [FULL_W-1:0] r_full;
    t_srel_cfg         w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_stored <= 5'd1;
            r_full   <= FULL_W'(1);
        end else if (i_cfg_we) begin
            case (t_srel_cfg_idx'(i_cfg_idx))
                CFG_BASE_OFFSET: begin
                    r_base <= i_cfg_data[BASE_W-1:0];
                end
                CFG_STORED_COLUMNS: begin
                    r_stored <= i_cfg_data[4:0];
                end
                CFG_FULL_COLUMNS: begin
                    r_full <= i_cfg_data[FULL_W-1:0];
                end
                default: begin
                    r_base <= r_base;
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.base   = r_base;
        w_cfg.full   = r_full;
        w_cfg.stored = (r_stored > 5'(MAX_STORED_COLS)) ? SLOT_W'(MAX_STORED_COLS)
                                                        : SLOT_W'(r_stored);
    end

    srel_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule

// ===== verif/sparse_row_element_locator_top_tb.sv =====
// Self-checking testbench for sparse_row_element_locator_top: directed table, then random row fills
// and lookups under several register settings, checked against a behavioral lookup predictor.
// Depends on srel_pkg and the sparse_row_element_locator_top RTL.
`timescale 1ns / 100ps

module sparse_row_element_locator_top_tb;
    import srel_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 24;

    typedef enum bit {
        DR_CFG,
        DR_REQ
    } t_dir_kind;

    typedef struct {
        t_dir_kind   kind;
        logic [31:0] base;
        logic [4:0]  stored;
        logic [12:0] full;
        t_srel_req   req;
        bit          typed;
        t_srel_res   res;
    } t_dir_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_srel_req             i_in_req   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_srel_res             o_out_res;

    logic [WORD_W-1:0] tbl_word [TABLE_DEPTH];
    bit                tbl_written [TABLE_DEPTH];
    logic [BASE_W-1:0] cfg_base   = '0;
    logic [4:0]        cfg_stored = 5'd1;
    logic [FULL_W-1:0] cfg_full   = 13'd1;

    t_srel_res   pending_res [$];
    t_dir_row    dir_tbl [$];
    int          err_cnt   = 0;
    int          item_cnt  = 0;
    int          gap_max   = 15;
    int          stall_max = 15;
    int          rx_wait   = 0;
    int unsigned cycle_cnt = 0;

    sparse_row_element_locator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_res  (o_out_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int eff_slots();
        return (int'(cfg_stored) > MAX_STORED_COLS) ? MAX_STORED_COLS : int'(cfg_stored);
    endfunction

    function automatic t_srel_res predict_lookup(t_srel_req r);
        t_srel_res       res;
        int              s;
        int              head;
        int              cnt;
        longint unsigned row_base;
        s = eff_slots();
        row_base = longint'(cfg_base) + longint'(r.row) * s;
        res = '0;
        if (int'(cfg_full) == s) begin
            res.found = 1'b1;
            res.index = INDEX_W'(row_base + r.col);
        end else begin
            head = int'(r.row) * (1 + s);
            cnt = int'(tbl_word[head]);
            if (cnt > s) cnt = s;
            for (int i = 0; i < cnt; i++) begin
                if (!res.found && tbl_word[head + 1 + i] == r.col) begin
                    res.found = 1'b1;
                    res.index = INDEX_W'(row_base + i);
                end
            end
        end
        return res;
    endfunction

    // A sparse lookup may only touch table words that already hold data.
    function automatic bit lookup_legal(int row);
        int s;
        int head;
        int cnt;
        bit ok;
        s = eff_slots();
        ok = 1'b1;
        if (int'(cfg_full) == s) return 1'b1;
        head = row * (1 + s);
        if (!tbl_written[head]) return 1'b0;
        cnt = int'(tbl_word[head]);
        if (cnt > s) cnt = s;
        for (int i = 0; i < cnt; i++) begin
            if (!tbl_written[head + 1 + i]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic t_srel_req make_req(logic cmd, int row, int col, int addr, int word);
        t_srel_req r;
        r.cmd        = cmd;
        r.row        = ROW_W'(row);
        r.col        = COL_W'(col);
        r.table_addr = ADDR_W'(addr);
        r.table_word = WORD_W'(word);
        return r;
    endfunction

    function automatic t_dir_row dr_cfg(logic [31:0] base, logic [4:0] stored, logic [12:0] full);
        t_dir_row d;
        d = '{DR_CFG, base, stored, full, '0, 1'b0, '0};
        return d;
    endfunction

    function automatic t_dir_row dr_wr(int addr, int word);
        t_dir_row d;
        d = '{DR_REQ, '0, '0, '0, make_req(CMD_WRITE, 0, 0, addr, word), 1'b0, '0};
        return d;
    endfunction

    function automatic t_dir_row dr_lk(int row, int col);
        t_dir_row d;
        d = '{DR_REQ, '0, '0, '0, make_req(CMD_LOOKUP, row, col, 0, 0), 1'b0, '0};
        return d;
    endfunction

    function automatic t_dir_row dr_lk_exp(int row, int col, logic found, logic [32:0] index);
        t_dir_row d;
        d = dr_lk(row, col);
        d.typed = 1'b1;
        d.res.found = found;
        d.res.index = index;
        return d;
    endfunction

    task automatic check_result(t_srel_res got);
        t_srel_res want;
        if (pending_res.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual found=%0d index=%0d",
                     $time, got.found, got.index);
            err_cnt++;
        end else begin
            want = pending_res.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found mismatch: expected %0d, actual %0d",
                         $time, want.found, got.found);
                err_cnt++;
            end
            if (got.index !== want.index) begin
                $display("%0t: index mismatch: expected %0d, actual %0d",
                         $time, want.index, got.index);
                err_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                check_result(o_out_res);
                rx_wait = $urandom_range(0, stall_max);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic issue(input t_srel_req r, input bit typed, input t_srel_res want);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        if (r.cmd == CMD_WRITE) begin
            if (int'(r.table_addr) < TABLE_DEPTH) begin
                tbl_word[r.table_addr]    = r.table_word;
                tbl_written[r.table_addr] = 1'b1;
                item_cnt++;
            end
        end else begin
            pending_res.push_back(typed ? want : predict_lookup(r));
            item_cnt++;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] base, logic [4:0] stored, logic [12:0] full);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE_OFFSET;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STORED_COLUMNS;
        i_cfg_data <= 32'(stored);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FULL_COLUMNS;
        i_cfg_data <= 32'(full);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_base   = base;
        cfg_stored = stored;
        cfg_full   = full;
    endtask

    task automatic random_config();
        int          stored;
        int          s;
        int          full;
        logic [31:0] base;
        case ($urandom_range(0, 9))
            0:       stored = $urandom_range(17, 31);
            1:       stored = 0;
            2:       stored = MAX_STORED_COLS;
            3:       stored = 1;
            default: stored = $urandom_range(1, MAX_STORED_COLS);
        endcase
        s = (stored > MAX_STORED_COLS) ? MAX_STORED_COLS : stored;
        if ($urandom_range(0, 2) == 0) begin
            full = s;
        end else begin
            full = $urandom_range(1, MAX_FULL_COLS);
            if (full == s) full = s + 1;
        end
        case ($urandom_range(0, 3))
            0:       base = 32'h0000_0000;
            1:       base = 32'hFFFF_FFFF;
            default: base = $urandom;
        endcase
        set_config(base, 5'(stored), 13'(full));
    endtask

    task automatic try_lookup(int row, int col);
        if (lookup_legal(row))
            issue(make_req(CMD_LOOKUP, row, col, $urandom_range(0, 8191),
                           $urandom_range(0, 4096)), 1'b0, '0);
    endtask

    // Writes one row's count and every slot, then probes it with matching and random columns.
    task automatic fill_row();
        int          s;
        int          row;
        int          head;
        int          cnt;
        int          col;
        logic [12:0] cols [16];
        s = eff_slots();
        row = $urandom_range(0, MAX_ROWS - 1);
        head = row * (1 + s);
        cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, s);
        issue(make_req(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 4095), head, cnt),
              1'b0, '0);
        for (int i = 0; i < s; i++) begin
            cols[i] = ($urandom_range(0, 15) == 0) ? 13'd4096 : 13'($urandom_range(0, 4095));
            if (i > 0 && $urandom_range(0, 3) == 0) cols[i] = cols[$urandom_range(0, i - 1)];
            issue(make_req(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 4095),
                           head + 1 + i, cols[i]), 1'b0, '0);
        end
        repeat ($urandom_range(1, 6)) begin
            col = $urandom_range(0, 4095);
            if (s > 0 && $urandom_range(0, 3) != 0) begin
                cols[0] = cols[$urandom_range(0, s - 1)];
                if (cols[0] != 13'd4096) col = int'(cols[0]);
            end
            try_lookup(row, col);
        end
    endtask

    task automatic noise();
        case ($urandom_range(0, 3))
            0: issue(make_req(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 4095),
                              $urandom_range(0, 8191), $urandom_range(0, 4096)), 1'b0, '0);
            1: issue(make_req(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 4095),
                              $urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 4096)),
                     1'b0, '0);
            default: try_lookup($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, 4095));
        endcase
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int target;
        dir_tbl = '{
            dr_lk_exp(0, 0, 1'b1, 33'd0),
            dr_lk_exp(255, 4095, 1'b1, 33'd4350),
            dr_cfg(32'hFFFF_FFFF, 5'd16, 13'd16),
            dr_lk_exp(255, 4095, 1'b1, 33'h1_0000_1FEE),
            dr_lk_exp(0, 0, 1'b1, 33'h0_FFFF_FFFF),
            dr_cfg(32'hFFFF_FFFF, 5'd20, 13'd16),
            dr_lk(1, 0),
            dr_cfg(32'd1000, 5'd4, 13'd100),
            dr_wr(10, 3),
            dr_wr(11, 7),
            dr_wr(12, 4095),
            dr_wr(13, 7),
            dr_wr(14, 4096),
            dr_lk_exp(2, 7, 1'b1, 33'd1008),
            dr_lk(2, 4095),
            dr_lk_exp(2, 5, 1'b0, 33'd0),
            dr_wr(8191, 4096),
            dr_wr(4352, 0),
            dr_lk(2, 7),
            dr_wr(15, 4096),
            dr_wr(16, 1),
            dr_wr(17, 2),
            dr_wr(18, 3),
            dr_wr(19, 4),
            dr_lk(3, 4),
            dr_cfg(32'd1000, 5'd0, 13'd0),
            dr_lk_exp(9, 77, 1'b1, 33'd1077),
            dr_cfg(32'd1000, 5'd0, 13'd5),
            dr_lk_exp(10, 0, 1'b0, 33'd0)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].kind == DR_CFG)
                set_config(dir_tbl[k].base, dir_tbl[k].stored, dir_tbl[k].full);
            else
                issue(dir_tbl[k].req, dir_tbl[k].typed, dir_tbl[k].res);
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       set_config(32'h0000_0000, 5'd16, 13'd4096);
                1:       set_config(32'hFFFF_FFFF, 5'd1, 13'd4096);
                2:       set_config(32'h8000_0000, 5'd16, 13'd16);
                3:       set_config(32'd12345, 5'd8, 13'd1);
                default: random_config();
            endcase
            gap_max   = (ph % 3 == 2) ? 0 : 15;
            stall_max = (ph % 3 == 2) ? 0 : 15;
            target = item_cnt + 200;
            while (item_cnt < target) begin
                if ($urandom_range(0, 9) < 7)
                    fill_row();
                else
                    noise();
            end
        end

        drain();
        if (err_cnt == 0 && pending_res.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
